[sv/rgbnv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbnv_pkg
// shared widths, coefficients and register codes of the rgb to nv12 converter
// ----------------------------------------------------------------------------
package rgbnv_pkg;

  // pixel and packed pair-sum layout
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned PAIR_CW = 9;                // one component of a pair sum
  localparam int unsigned PAIR_W  = 3 * PAIR_CW;      // r | g << 9 | b << 18

  // register port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_index_e;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd320;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd180;

  // output offset widths
  localparam int unsigned LUMA_OFS_W   = 24;
  localparam int unsigned CHROMA_OFS_W = 25;

  // bt.601 limited-range coefficients (magnitudes, signs applied in the sums)
  localparam logic [7:0] Y_R  = 8'd66;
  localparam logic [7:0] Y_G  = 8'd129;
  localparam logic [7:0] Y_B  = 8'd25;
  localparam logic [7:0] CB_R = 8'd38;
  localparam logic [7:0] CB_G = 8'd74;
  localparam logic [7:0] CB_B = 8'd112;
  localparam logic [7:0] CR_R = 8'd112;
  localparam logic [7:0] CR_G = 8'd94;
  localparam logic [7:0] CR_B = 8'd18;
  localparam logic [7:0] ROUND_HALF  = 8'd128;
  localparam logic [7:0] LUMA_BASE   = 8'd16;
  localparam logic [7:0] CHROMA_BASE = 8'd128;
  localparam logic [7:0] U8_MAX      = 8'd255;

endpackage

[sv/rgb_to_nv12_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter
// streaming bt.601 limited-range rgb to nv12 pixel converter with line store
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  pixel in | in        | in_valid_i / in_stall_o    | red, green, blue, frame_start
//  result   | out       | out_valid_o / out_stall_i  | luma, offsets, chroma, done
//  config   | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  one pixel per clock sustained while the output is not stalled; an accepted
//  request passes stage a, then stage b, then output register c
//  the rate is set by the single-port line store: each pixel does at most one
//  access (write on upper rows, read on lower rows of a 2x2 block)
//  reset clears counters, pair sum and stage valids; the line store is not
//  cleared, an entry is always written by the upper row before it is read
//  a stall at the output backs up stage by stage; empty stages keep filling,
//  so input is still taken while a finished result waits
//
module rgb_to_nv12_converter
  import rgbnv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COMP_W-1:0]       red_i,
  input  logic [COMP_W-1:0]       green_i,
  input  logic [COMP_W-1:0]       blue_i,
  input  logic                    frame_start_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COMP_W-1:0]       luma_o,
  output logic [LUMA_OFS_W-1:0]   luma_offset_o,
  output logic                    chroma_valid_o,
  output logic [COMP_W-1:0]       chroma_blue_o,
  output logic [COMP_W-1:0]       chroma_red_o,
  output logic [CHROMA_OFS_W-1:0] chroma_offset_o,
  output logic                    frame_done_o
);

  // counter and size widths
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned W_W        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned SUM_W      = (H_W + W_W + 2 > CHROMA_OFS_W) ?
                                       (H_W + W_W + 2) : CHROMA_OFS_W;
  localparam int unsigned SIZE_W     = CFG_DATA_W + 1;

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective sizes: drop bit 0, saturate to 2..max
  logic [SIZE_W-1:0] w_raw, h_raw;
  logic [W_W-1:0]    w_eff;
  logic [H_W-1:0]    h_eff;

  always_comb begin
    w_raw = {1'b0, frame_width_q[CFG_DATA_W-1:1], 1'b0};
    if (w_raw < SIZE_W'(2)) w_raw = SIZE_W'(2);
    if (w_raw > SIZE_W'(MAX_WIDTH)) w_raw = SIZE_W'(MAX_WIDTH);
    w_eff = w_raw[W_W-1:0];
  end

  always_comb begin
    h_raw = {1'b0, frame_height_q[CFG_DATA_W-1:1], 1'b0};
    if (h_raw < SIZE_W'(2)) h_raw = SIZE_W'(2);
    if (h_raw > SIZE_W'(MAX_HEIGHT)) h_raw = SIZE_W'(MAX_HEIGHT);
    h_eff = h_raw[H_W-1:0];
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic a_vld_q, b_vld_q, c_vld_q;
  logic a_en, b_en, c_en;
  logic in_accept;

  assign c_en      = !c_vld_q || !out_stall_i;
  assign b_en      = !b_vld_q || c_en;
  assign a_en      = !a_vld_q || b_en;
  assign in_stall_o = !a_en;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_en) a_vld_q <= in_accept;
      if (b_en) b_vld_q <= a_vld_q;
      if (c_en) c_vld_q <= b_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // accept: raster position, pair sum, line store access
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_q, col_d, col_cur;
  logic [ROW_W-1:0]  row_q, row_d, row_cur;
  logic [PAIR_W-1:0] pair_q, pair_d, packed_px;
  logic              last_col, last_row;
  logic [COL_W-1:0]  idx_full;
  logic              line_hit;
  logic [IDX_W-1:0]  line_addr;
  logic              mem_wr, mem_rd, is_chroma;

  always_comb begin
    col_cur   = frame_start_i ? '0 : col_q;
    row_cur   = frame_start_i ? '0 : row_q;
    // a counter at or beyond the last place counts as the last one
    last_col  = W_W'(col_cur) >= (w_eff - W_W'(1));
    last_row  = H_W'(row_cur) >= (h_eff - H_W'(1));
    packed_px = {1'b0, blue_i, 1'b0, green_i, 1'b0, red_i};
    pair_d    = col_cur[0] ? (pair_q + packed_px) : packed_px;
    idx_full  = col_cur >> 1;
    line_hit  = 32'(idx_full) < LINE_DEPTH;
    line_addr = idx_full[IDX_W-1:0];
    mem_wr    = in_accept && col_cur[0] && !row_cur[0] && line_hit;
    mem_rd    = in_accept && col_cur[0] &&  row_cur[0] && line_hit;
    is_chroma = col_cur[0] && row_cur[0] && line_hit;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pair_q <= '0;
    end else if (in_accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pair_q <= pair_d;
    end
  end

  // line store of upper-row pair sums; reads and writes fall on different
  // rows, so the same entry is never written and read in one cycle
  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr) line_mem[line_addr] <= pair_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd) mem_rd_q <= line_mem[line_addr];
  end

  // stage a payload
  logic [COMP_W-1:0] a_r_q, a_g_q, a_b_q;
  logic [COL_W-1:0]  a_col_q;
  logic [ROW_W-1:0]  a_row_q;
  logic [W_W-1:0]    a_w_q;
  logic [H_W-1:0]    a_h_q;
  logic [PAIR_W-1:0] a_pair_q;
  logic              a_chroma_q, a_done_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_r_q      <= red_i;
      a_g_q      <= green_i;
      a_b_q      <= blue_i;
      a_col_q    <= col_cur;
      a_row_q    <= row_cur;
      a_w_q      <= w_eff;
      a_h_q      <= h_eff;
      a_pair_q   <= pair_d;
      a_chroma_q <= is_chroma;
      a_done_q   <= last_col && last_row;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: luma, block averages, offset products
  // --------------------------------------------------------------------------
  logic [16:0]          l_sum;
  logic [9:0]           l_val;
  logic [COMP_W-1:0]    luma_d;
  logic [PAIR_CW:0]     sum_r, sum_g, sum_b;

  always_comb begin
    l_sum = 17'(Y_R) * 17'(a_r_q) + 17'(Y_G) * 17'(a_g_q) + 17'(Y_B) * 17'(a_b_q)
          + 17'(ROUND_HALF);
    l_val = 10'(l_sum >> 8) + 10'(LUMA_BASE);
    luma_d = (l_val > 10'(U8_MAX)) ? U8_MAX : l_val[COMP_W-1:0];
    sum_r = 10'(mem_rd_q[PAIR_CW-1:0])          + 10'(a_pair_q[PAIR_CW-1:0]);
    sum_g = 10'(mem_rd_q[2*PAIR_CW-1:PAIR_CW])  + 10'(a_pair_q[2*PAIR_CW-1:PAIR_CW]);
    sum_b = 10'(mem_rd_q[PAIR_W-1:2*PAIR_CW])   + 10'(a_pair_q[PAIR_W-1:2*PAIR_CW]);
  end

  logic [COMP_W-1:0]    b_luma_q, b_ar_q, b_ag_q, b_ab_q;
  logic [ROW_W+W_W-1:0] b_lprod_q;
  logic [H_W+W_W-1:0]   b_area_q;
  logic [COL_W-1:0]     b_col_q;
  logic [ROW_W-1:0]     b_row_q;
  logic [W_W-1:0]       b_w_q;
  logic                 b_chroma_q, b_done_q;

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_luma_q   <= luma_d;
      b_ar_q     <= sum_r[PAIR_CW:2];
      b_ag_q     <= sum_g[PAIR_CW:2];
      b_ab_q     <= sum_b[PAIR_CW:2];
      b_lprod_q  <= (ROW_W+W_W)'(a_row_q) * (ROW_W+W_W)'(a_w_q);
      b_area_q   <= (H_W+W_W)'(a_h_q) * (H_W+W_W)'(a_w_q);
      b_col_q    <= a_col_q;
      b_row_q    <= a_row_q;
      b_w_q      <= a_w_q;
      b_chroma_q <= a_chroma_q;
      b_done_q   <= a_done_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage c: chroma sums, offsets, output register
  // --------------------------------------------------------------------------
  logic signed [16:0]   ar_s, ag_s, ab_s;
  logic signed [16:0]   cb_sum, cr_sum, cb_val, cr_val;
  logic [COMP_W-1:0]    cb_d, cr_d;
  logic [ROW_W+W_W-1:0] half_prod;
  logic [SUM_W-1:0]     lofs_sum, cofs_sum;

  always_comb begin
    ar_s   = signed'(17'(b_ar_q));
    ag_s   = signed'(17'(b_ag_q));
    ab_s   = signed'(17'(b_ab_q));
    cb_sum = signed'(17'(ROUND_HALF)) - signed'(17'(CB_R)) * ar_s
           - signed'(17'(CB_G)) * ag_s + signed'(17'(CB_B)) * ab_s;
    cr_sum = signed'(17'(ROUND_HALF)) + signed'(17'(CR_R)) * ar_s
           - signed'(17'(CR_G)) * ag_s - signed'(17'(CR_B)) * ab_s;
    // floor shift, then offset to the unsigned chroma range
    cb_val = (cb_sum >>> 8) + signed'(17'(CHROMA_BASE));
    cr_val = (cr_sum >>> 8) + signed'(17'(CHROMA_BASE));
    if (cb_val < 0)                            cb_d = '0;
    else if (cb_val > signed'(17'(U8_MAX)))    cb_d = U8_MAX;
    else                                       cb_d = cb_val[COMP_W-1:0];
    if (cr_val < 0)                            cr_d = '0;
    else if (cr_val > signed'(17'(U8_MAX)))    cr_d = U8_MAX;
    else                                       cr_d = cr_val[COMP_W-1:0];
    half_prod = (ROW_W+W_W)'(b_row_q >> 1) * (ROW_W+W_W)'(b_w_q);
    lofs_sum  = SUM_W'(b_lprod_q) + SUM_W'(b_col_q);
    // column is odd on a chroma pixel, so col - 1 does not wrap
    cofs_sum  = SUM_W'(b_area_q) + SUM_W'(half_prod) + SUM_W'(b_col_q)
              - SUM_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      luma_o          <= b_luma_q;
      luma_offset_o   <= lofs_sum[LUMA_OFS_W-1:0];
      chroma_valid_o  <= b_chroma_q;
      chroma_blue_o   <= b_chroma_q ? cb_d : '0;
      chroma_red_o    <= b_chroma_q ? cr_d : '0;
      chroma_offset_o <= b_chroma_q ? cofs_sum[CHROMA_OFS_W-1:0] : '0;
      frame_done_o    <= b_done_q;
    end
  end

  assign out_valid_o = c_vld_q;

`ifndef SYNTHESIS
  // the single-port line store never sees a read and a write together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_wr && mem_rd))
    else $error("line store read and write in the same cycle");

  // chroma pixels sit on an odd column of an even-width line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_valid_o |-> luma_offset_o[0])
    else $error("chroma result on an even luma offset");

  // interleaved cb/cr pairs start on even offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_valid_o |-> !chroma_offset_o[0])
    else $error("chroma offset is odd");

  // non-chroma results carry zero chroma fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |->
      (chroma_blue_o == '0) && (chroma_red_o == '0) && (chroma_offset_o == '0))
    else $error("chroma fields set without chroma_valid");

  // a read of the store only issues when the accepted pixel is a chroma pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd |=> a_vld_q && a_chroma_q)
    else $error("line store read not matched by a chroma request");
`endif

endmodule
